FILE: hdl/lpi_pkg.sv
// Shared widths, word types and saturation limits for the line pair intersection core.
// No dependencies; every other file but lpi_checker imports this package.
package lpi_pkg;

  localparam int CoordW   = 24;
  localparam int DiffW    = 25;
  localparam int ProdW    = 48;
  localparam int CrossW   = 49;
  localparam int DpW      = 50;
  localparam int DenW     = 51;
  localparam int NumW     = 75;
  localparam int QW       = 32;
  localparam int RemW     = 51;
  localparam int SplitW   = 24;
  localparam int DivSteps = 32;
  localparam int FrontStages = 6;

  localparam int MidDepth = 4;
  localparam int MidPtrW  = $clog2(MidDepth);
  localparam int ResDepth = 2;
  localparam int ResPtrW  = $clog2(ResDepth);

  localparam logic [QW-1:0] PosMax = 32'h7FFF_FFFF;
  localparam logic [QW-1:0] NegMag = 32'h8000_0000;

  typedef struct packed {
    logic signed [NumW-1:0] num_x;
    logic signed [NumW-1:0] num_y;
    logic signed [DenW-1:0] den;
    logic                   par;
  } mid_t;

  typedef struct packed {
    logic [RemW-1:0] rem_x;
    logic [QW-1:0]   w_x;
    logic [RemW-1:0] rem_y;
    logic [QW-1:0]   w_y;
    logic [DenW-1:0] dmag;
    logic            neg_x;
    logic            neg_y;
    logic            ovf_x;
    logic            ovf_y;
    logic            par;
  } div_t;

  typedef struct packed {
    logic [QW-1:0] hit_x;
    logic [QW-1:0] hit_y;
    logic          parallel;
    logic          saturated;
  } res_t;

endpackage

FILE: hdl/lpi_front.sv
// Front pipeline: cross products, denominator and numerators, parallel detection.
// Depends on lpi_pkg.
module lpi_front import lpi_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic                     vld_i,
  input  logic signed [CoordW-1:0] ax_i,
  input  logic signed [CoordW-1:0] ay_i,
  input  logic signed [CoordW-1:0] bx_i,
  input  logic signed [CoordW-1:0] by_coord_i,
  input  logic signed [CoordW-1:0] cx_i,
  input  logic signed [CoordW-1:0] cy_i,
  input  logic signed [CoordW-1:0] dx_i,
  input  logic signed [CoordW-1:0] dy_i,
  output logic                     vld_o,
  output mid_t                     mid_o
);

  logic [FrontStages-1:0] vld_q;

  logic signed [CoordW-1:0] s1_ax_q, s1_ay_q, s1_bx_q, s1_by_q;
  logic signed [CoordW-1:0] s1_cx_q, s1_cy_q, s1_dx_q, s1_dy_q;

  logic signed [ProdW-1:0]  s2_p1_q, s2_p2_q, s2_p3_q, s2_p4_q;
  logic signed [DiffW-1:0]  s2_d12x_q, s2_d12y_q, s2_d34x_q, s2_d34y_q;
  logic signed [CoordW-1:0] s2_x1_q, s2_y1_q;

  logic signed [CrossW-1:0] s3_a_q, s3_b_q;
  logic signed [DpW-1:0]    s3_dp1_q, s3_dp2_q;
  logic signed [DiffW-1:0]  s3_d12x_q, s3_d12y_q, s3_d34x_q, s3_d34y_q;
  logic signed [CoordW-1:0] s3_x1_q, s3_y1_q;

  logic signed [DiffW-1:0]  a_hi, a_lo, b_hi, b_lo;
  logic signed [DenW-1:0]   s4_den_q;
  logic signed [DpW-1:0]    s4_ahx_q, s4_alx_q, s4_ahy_q, s4_aly_q;
  logic signed [DpW-1:0]    s4_bhx_q, s4_blx_q, s4_bhy_q, s4_bly_q;
  logic signed [CoordW-1:0] s4_x1_q, s4_y1_q;

  logic [NumW-1:0]          s5_tax_q, s5_tay_q, s5_tbx_q, s5_tby_q;
  logic signed [DenW-1:0]   s5_den_q;
  logic                     s5_zero_q;
  logic signed [CoordW-1:0] s5_x1_q, s5_y1_q;

  mid_t mid_d, mid_q;

  function automatic logic [NumW-1:0] join_pp(logic [DpW-1:0] hi, logic [DpW-1:0] lo);
    return {hi[DpW-1], hi, {SplitW{1'b0}}} + {{(NumW-DpW){lo[DpW-1]}}, lo};
  endfunction

  assign a_hi = s3_a_q[CrossW-1:SplitW];
  assign a_lo = {1'b0, s3_a_q[SplitW-1:0]};
  assign b_hi = s3_b_q[CrossW-1:SplitW];
  assign b_lo = {1'b0, s3_b_q[SplitW-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[FrontStages-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_ax_q <= ax_i;
      s1_ay_q <= ay_i;
      s1_bx_q <= bx_i;
      s1_by_q <= by_coord_i;
      s1_cx_q <= cx_i;
      s1_cy_q <= cy_i;
      s1_dx_q <= dx_i;
      s1_dy_q <= dy_i;

      s2_p1_q   <= s1_ax_q * s1_by_q;
      s2_p2_q   <= s1_ay_q * s1_bx_q;
      s2_p3_q   <= s1_cx_q * s1_dy_q;
      s2_p4_q   <= s1_cy_q * s1_dx_q;
      s2_d12x_q <= {s1_ax_q[CoordW-1], s1_ax_q} - {s1_bx_q[CoordW-1], s1_bx_q};
      s2_d12y_q <= {s1_ay_q[CoordW-1], s1_ay_q} - {s1_by_q[CoordW-1], s1_by_q};
      s2_d34x_q <= {s1_cx_q[CoordW-1], s1_cx_q} - {s1_dx_q[CoordW-1], s1_dx_q};
      s2_d34y_q <= {s1_cy_q[CoordW-1], s1_cy_q} - {s1_dy_q[CoordW-1], s1_dy_q};
      s2_x1_q   <= s1_ax_q;
      s2_y1_q   <= s1_ay_q;

      s3_a_q    <= {s2_p1_q[ProdW-1], s2_p1_q} - {s2_p2_q[ProdW-1], s2_p2_q};
      s3_b_q    <= {s2_p3_q[ProdW-1], s2_p3_q} - {s2_p4_q[ProdW-1], s2_p4_q};
      s3_dp1_q  <= s2_d12x_q * s2_d34y_q;
      s3_dp2_q  <= s2_d12y_q * s2_d34x_q;
      s3_d12x_q <= s2_d12x_q;
      s3_d12y_q <= s2_d12y_q;
      s3_d34x_q <= s2_d34x_q;
      s3_d34y_q <= s2_d34y_q;
      s3_x1_q   <= s2_x1_q;
      s3_y1_q   <= s2_y1_q;

      s4_den_q <= {s3_dp1_q[DpW-1], s3_dp1_q} - {s3_dp2_q[DpW-1], s3_dp2_q};
      s4_ahx_q <= a_hi * s3_d34x_q;
      s4_alx_q <= a_lo * s3_d34x_q;
      s4_ahy_q <= a_hi * s3_d34y_q;
      s4_aly_q <= a_lo * s3_d34y_q;
      s4_bhx_q <= b_hi * s3_d12x_q;
      s4_blx_q <= b_lo * s3_d12x_q;
      s4_bhy_q <= b_hi * s3_d12y_q;
      s4_bly_q <= b_lo * s3_d12y_q;
      s4_x1_q  <= s3_x1_q;
      s4_y1_q  <= s3_y1_q;

      s5_tax_q  <= join_pp(s4_ahx_q, s4_alx_q);
      s5_tay_q  <= join_pp(s4_ahy_q, s4_aly_q);
      s5_tbx_q  <= join_pp(s4_bhx_q, s4_blx_q);
      s5_tby_q  <= join_pp(s4_bhy_q, s4_bly_q);
      s5_den_q  <= s4_den_q;
      s5_zero_q <= (s4_den_q == '0);
      s5_x1_q   <= s4_x1_q;
      s5_y1_q   <= s4_y1_q;

      mid_q <= mid_d;
    end
  end

  // substitute the first point with a unit divisor when the denominator is zero
  always_comb begin
    if (s5_zero_q) begin
      mid_d.num_x = {{(NumW-CoordW){s5_x1_q[CoordW-1]}}, s5_x1_q};
      mid_d.num_y = {{(NumW-CoordW){s5_y1_q[CoordW-1]}}, s5_y1_q};
      mid_d.den   = DenW'(1);
      mid_d.par   = 1'b1;
    end else begin
      mid_d.num_x = s5_tax_q - s5_tbx_q;
      mid_d.num_y = s5_tay_q - s5_tby_q;
      mid_d.den   = s5_den_q;
      mid_d.par   = 1'b0;
    end
  end

  assign vld_o = vld_q[FrontStages-1];
  assign mid_o = mid_q;

endmodule

FILE: hdl/lpi_mid_queue.sv
// Short queue between front and back pipelines, one mid_t word per entry.
// Depends on lpi_pkg.
module lpi_mid_queue import lpi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  mid_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output mid_t data_o
);

  mid_t               mem_q [MidDepth];
  logic [MidPtrW-1:0] wr_q, rd_q;
  logic [MidPtrW:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == (MidPtrW+1)'(MidDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cnt_d   = cnt_q + {{MidPtrW{1'b0}}, do_push} - {{MidPtrW{1'b0}}, do_pop};
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

FILE: hdl/lpi_back.sv
// Back pipeline: magnitudes, overflow check, one quotient bit per stage, saturation.
// Depends on lpi_pkg.
module lpi_back import lpi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic adv_i,
  input  logic vld_i,
  input  mid_t mid_i,
  output logic vld_o,
  output res_t res_o
);

  logic            b1_vld_q;
  logic [NumW-1:0] b1_mag_x_q, b1_mag_y_q;
  logic [DenW-1:0] b1_dmag_q;
  logic            b1_neg_x_q, b1_neg_y_q, b1_par_q;

  logic [DivSteps:0] dv_q;
  div_t              div_q [DivSteps+1];
  div_t              dv0_d;

  logic              fin_vld_q;
  res_t              res_q, res_d;
  logic              sat_x, sat_y;
  logic [QW-1:0]     val_x, val_y;

  function automatic logic [RemW+QW-1:0] div_bit(logic [RemW-1:0] rem, logic [QW-1:0] w,
                                                 logic [DenW-1:0] dmag);
    logic [RemW:0] r;
    logic [RemW:0] s;
    logic          ge;
    r  = {rem, w[QW-1]};
    s  = r - {1'b0, dmag};
    ge = (r >= {1'b0, dmag});
    return {ge ? s[RemW-1:0] : r[RemW-1:0], w[QW-2:0], ge};
  endfunction

  function automatic div_t div_step(div_t d);
    div_t n;
    n = d;
    {n.rem_x, n.w_x} = div_bit(d.rem_x, d.w_x, d.dmag);
    {n.rem_y, n.w_y} = div_bit(d.rem_y, d.w_y, d.dmag);
    return n;
  endfunction

  function automatic logic [QW:0] clip(logic [QW-1:0] q, logic neg, logic ovf);
    logic [QW:0] r;
    if (!neg) begin
      if (ovf || q > PosMax) r = {1'b1, PosMax};
      else r = {1'b0, q};
    end else begin
      if (ovf || q > NegMag) r = {1'b1, NegMag};
      else r = {1'b0, QW'(0) - q};
    end
    return r;
  endfunction

  always_comb begin
    dv0_d.ovf_x = ({8'b0, b1_mag_x_q} >= {b1_dmag_q, {QW{1'b0}}});
    dv0_d.ovf_y = ({8'b0, b1_mag_y_q} >= {b1_dmag_q, {QW{1'b0}}});
    dv0_d.rem_x = {8'b0, b1_mag_x_q[NumW-1:QW]};
    dv0_d.rem_y = {8'b0, b1_mag_y_q[NumW-1:QW]};
    dv0_d.w_x   = b1_mag_x_q[QW-1:0];
    dv0_d.w_y   = b1_mag_y_q[QW-1:0];
    dv0_d.dmag  = b1_dmag_q;
    dv0_d.neg_x = b1_neg_x_q;
    dv0_d.neg_y = b1_neg_y_q;
    dv0_d.par   = b1_par_q;
  end

  always_comb begin
    {sat_x, val_x} = clip(div_q[DivSteps].w_x, div_q[DivSteps].neg_x, div_q[DivSteps].ovf_x);
    {sat_y, val_y} = clip(div_q[DivSteps].w_y, div_q[DivSteps].neg_y, div_q[DivSteps].ovf_y);
    res_d.hit_x     = val_x;
    res_d.hit_y     = val_y;
    res_d.parallel  = div_q[DivSteps].par;
    res_d.saturated = sat_x | sat_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_vld_q  <= 1'b0;
      dv_q      <= '0;
      fin_vld_q <= 1'b0;
    end else if (adv_i) begin
      b1_vld_q  <= vld_i;
      dv_q      <= {dv_q[DivSteps-1:0], b1_vld_q};
      fin_vld_q <= dv_q[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      b1_mag_x_q <= mid_i.num_x[NumW-1] ? NumW'(0) - mid_i.num_x : mid_i.num_x;
      b1_mag_y_q <= mid_i.num_y[NumW-1] ? NumW'(0) - mid_i.num_y : mid_i.num_y;
      b1_dmag_q  <= mid_i.den[DenW-1] ? DenW'(0) - mid_i.den : mid_i.den;
      b1_neg_x_q <= mid_i.num_x[NumW-1] ^ mid_i.den[DenW-1];
      b1_neg_y_q <= mid_i.num_y[NumW-1] ^ mid_i.den[DenW-1];
      b1_par_q   <= mid_i.par;
      div_q[0]   <= dv0_d;
      for (int k = 0; k < DivSteps; k++) begin
        div_q[k+1] <= div_step(div_q[k]);
      end
      res_q <= res_d;
    end
  end

  assign vld_o = fin_vld_q;
  assign res_o = res_q;

endmodule

FILE: hdl/lpi_res_queue.sv
// Result queue feeding the output ports, one res_t word per entry.
// Depends on lpi_pkg.
module lpi_res_queue import lpi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output res_t data_o
);

  res_t               mem_q [ResDepth];
  logic [ResPtrW-1:0] wr_q, rd_q;
  logic [ResPtrW:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == (ResPtrW+1)'(ResDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cnt_d   = cnt_q + {{ResPtrW{1'b0}}, do_push} - {{ResPtrW{1'b0}}, do_pop};
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

FILE: hdl/line_pair_intersection_core.sv
// Top level of the line pair intersection core: front, mid queue, back, result queue.
// Depends on lpi_pkg, lpi_front, lpi_mid_queue, lpi_back, lpi_res_queue.
//
//   channel  | handshake        | word
//   ---------+------------------+---------------------------------------------
//   input    | push / full      | ax, ay, bx, by_coord, cx, cy, dx, dy (Q16.8)
//   result   | pop / empty      | hit_x, hit_y (Q24.8), parallel, saturated
//
// One word accepted per cycle while full is low; an accepted word passes through
// 6 front stages, mid queue, 35 back stages set by the 32-step quotient pipe, result queue.
// Reset clears all valid bits and queue pointers; payload registers are not reset.
// A full result queue stalls the back part, a full mid queue then stalls the front.
module line_pair_intersection_core import lpi_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push,
  output logic                     full,
  input  logic signed [CoordW-1:0] ax_i,
  input  logic signed [CoordW-1:0] ay_i,
  input  logic signed [CoordW-1:0] bx_i,
  input  logic signed [CoordW-1:0] by_coord_i,
  input  logic signed [CoordW-1:0] cx_i,
  input  logic signed [CoordW-1:0] cy_i,
  input  logic signed [CoordW-1:0] dx_i,
  input  logic signed [CoordW-1:0] dy_i,
  input  logic                     pop,
  output logic                     empty,
  output logic signed [QW-1:0]     hit_x_o,
  output logic signed [QW-1:0]     hit_y_o,
  output logic                     parallel_o,
  output logic                     saturated_o
);

  logic front_adv, back_adv;
  logic f_vld, b_vld;
  logic mid_full, mid_empty, res_full;
  mid_t f_mid, q_mid;
  res_t b_res, q_res;

  assign front_adv = !(f_vld && mid_full);
  assign back_adv  = !(b_vld && res_full);
  assign full      = !front_adv;

  lpi_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (front_adv),
    .vld_i      (push),
    .ax_i       (ax_i),
    .ay_i       (ay_i),
    .bx_i       (bx_i),
    .by_coord_i (by_coord_i),
    .cx_i       (cx_i),
    .cy_i       (cy_i),
    .dx_i       (dx_i),
    .dy_i       (dy_i),
    .vld_o      (f_vld),
    .mid_o      (f_mid)
  );

  lpi_mid_queue u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_vld),
    .data_i  (f_mid),
    .full_o  (mid_full),
    .pop_i   (back_adv),
    .empty_o (mid_empty),
    .data_o  (q_mid)
  );

  lpi_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (back_adv),
    .vld_i  (!mid_empty),
    .mid_i  (q_mid),
    .vld_o  (b_vld),
    .res_o  (b_res)
  );

  lpi_res_queue u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (b_vld),
    .data_i  (b_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (q_res)
  );

  assign hit_x_o     = q_res.hit_x;
  assign hit_y_o     = q_res.hit_y;
  assign parallel_o  = q_res.parallel;
  assign saturated_o = q_res.saturated;

endmodule

FILE: hdl/lpi_checker.sv
// Port-level checks on the result side of the line pair intersection core.
// Bound to line_pair_intersection_core; no package dependency.
module lpi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pop,
  input logic        empty,
  input logic [31:0] hit_x_o,
  input logic [31:0] hit_y_o,
  input logic        parallel_o,
  input logic        saturated_o
);

  a_hold_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("result word dropped while stalled");

  a_hold_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(hit_x_o) && $stable(hit_y_o) && $stable(parallel_o)
                       && $stable(saturated_o))
    else $error("result word changed while stalled");

  a_par_nosat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && parallel_o |-> !saturated_o)
    else $error("parallel result flagged saturated");

  a_par_point : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && parallel_o |->
      (hit_x_o[31:23] == 9'h000 || hit_x_o[31:23] == 9'h1FF) &&
      (hit_y_o[31:23] == 9'h000 || hit_y_o[31:23] == 9'h1FF))
    else $error("parallel result is not a sign-extended input point");

  a_sat_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && saturated_o |->
      hit_x_o == 32'h7FFF_FFFF || hit_x_o == 32'h8000_0000 ||
      hit_y_o == 32'h7FFF_FFFF || hit_y_o == 32'h8000_0000)
    else $error("saturated result not at a range limit");

endmodule

bind line_pair_intersection_core lpi_checker u_lpi_checker (.*);

FILE: tb/sv/tb_line_pair_intersection_checker.sv
`timescale 1ns / 100ps
// Checker for the line pair intersection core: predicts each result from the accepted input
// word and compares it with the word popped from the result side. Depends on lpi_pkg.
module tb_line_pair_intersection_checker import lpi_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  logic                     full_i,
  input  logic signed [CoordW-1:0] ax_i,
  input  logic signed [CoordW-1:0] ay_i,
  input  logic signed [CoordW-1:0] bx_i,
  input  logic signed [CoordW-1:0] by_coord_i,
  input  logic signed [CoordW-1:0] cx_i,
  input  logic signed [CoordW-1:0] cy_i,
  input  logic signed [CoordW-1:0] dx_i,
  input  logic signed [CoordW-1:0] dy_i,
  input  logic                     pop_i,
  input  logic                     empty_i,
  input  logic signed [QW-1:0]     hit_x_i,
  input  logic signed [QW-1:0]     hit_y_i,
  input  logic                     parallel_i,
  input  logic                     saturated_i,
  output int                       fail_cnt_o,
  output int                       pending_o
);

  res_t hit_q[$];

  function automatic res_t calc_hit(logic signed [CoordW-1:0] pax, pay, pbx, pby,
                                    pcx, pcy, pdx, pdy);
    logic signed [127:0] x1, y1, x2, y2, x3, y3, x4, y4;
    logic signed [127:0] d12x, d12y, d34x, d34y, den, ca, cb, nx, ny, qx, qy;
    res_t r;
    x1 = pax; y1 = pay; x2 = pbx; y2 = pby;
    x3 = pcx; y3 = pcy; x4 = pdx; y4 = pdy;
    d12x = x1 - x2; d12y = y1 - y2; d34x = x3 - x4; d34y = y3 - y4;
    den = d12x * d34y - d12y * d34x;
    r.saturated = 1'b0;
    if (den == 0) begin
      r.hit_x = x1[QW-1:0];
      r.hit_y = y1[QW-1:0];
      r.parallel = 1'b1;
      return r;
    end
    ca = x1 * y2 - y1 * x2;
    cb = x3 * y4 - y3 * x4;
    nx = ca * d34x - d12x * cb;
    ny = ca * d34y - d12y * cb;
    qx = nx / den;
    qy = ny / den;
    r.parallel = 1'b0;
    if (qx > 128'sd2147483647) begin
      qx = 128'sd2147483647; r.saturated = 1'b1;
    end else if (qx < -128'sd2147483648) begin
      qx = -128'sd2147483648; r.saturated = 1'b1;
    end
    if (qy > 128'sd2147483647) begin
      qy = 128'sd2147483647; r.saturated = 1'b1;
    end else if (qy < -128'sd2147483648) begin
      qy = -128'sd2147483648; r.saturated = 1'b1;
    end
    r.hit_x = qx[QW-1:0];
    r.hit_y = qy[QW-1:0];
    return r;
  endfunction

  initial fail_cnt_o = 0;
  assign pending_o = hit_q.size();

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && push_i && !full_i) begin
      hit_q.push_back(calc_hit(ax_i, ay_i, bx_i, by_coord_i, cx_i, cy_i, dx_i, dy_i));
    end
    if (rst_ni && pop_i && !empty_i) begin
      if (hit_q.size() == 0) begin
        $display("%0t: result word with nothing expected: x %h y %h", $time, hit_x_i, hit_y_i);
        fail_cnt_o <= fail_cnt_o + 1;
      end else begin
        want = hit_q.pop_front();
        if (want.hit_x !== hit_x_i || want.hit_y !== hit_y_i ||
            want.parallel !== parallel_i || want.saturated !== saturated_i) begin
          $display("%0t: mismatch expected x %h y %h par %b sat %b, actual x %h y %h par %b sat %b",
                   $time, want.hit_x, want.hit_y, want.parallel, want.saturated,
                   hit_x_i, hit_y_i, parallel_i, saturated_i);
          fail_cnt_o <= fail_cnt_o + 1;
        end
      end
    end
  end

endmodule

FILE: tb/sv/tb_line_pair_intersection_core.sv
`timescale 1ns / 100ps
// Testbench top for line_pair_intersection_core: drives directed and random line pairs with
// random gaps on both sides and gives the verdict. Depends on lpi_pkg and the checker module.
module tb_line_pair_intersection_core;
  import lpi_pkg::*;

  localparam int NumRand   = 1250;
  localparam int IdleLimit = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic signed [CoordW-1:0] ax = '0, ay = '0, bx = '0, by_c = '0;
  logic signed [CoordW-1:0] cx = '0, cy = '0, dx = '0, dy = '0;
  logic signed [QW-1:0] hit_x, hit_y;
  logic parallel, saturated;
  int fail_cnt, pending, idle_cnt;

  always #5 clk_i = ~clk_i;

  line_pair_intersection_core i_dut (
    .clk_i, .rst_ni, .push, .full,
    .ax_i(ax), .ay_i(ay), .bx_i(bx), .by_coord_i(by_c),
    .cx_i(cx), .cy_i(cy), .dx_i(dx), .dy_i(dy),
    .pop, .empty, .hit_x_o(hit_x), .hit_y_o(hit_y),
    .parallel_o(parallel), .saturated_o(saturated)
  );

  tb_line_pair_intersection_checker i_chk (
    .clk_i, .rst_ni, .push_i(push), .full_i(full),
    .ax_i(ax), .ay_i(ay), .bx_i(bx), .by_coord_i(by_c),
    .cx_i(cx), .cy_i(cy), .dx_i(dx), .dy_i(dy),
    .pop_i(pop), .empty_i(empty), .hit_x_i(hit_x), .hit_y_i(hit_y),
    .parallel_i(parallel), .saturated_i(saturated),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  task automatic send_pair(int a0, a1, b0, b1, c0, c1, d0, d1);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    ax <= CoordW'(a0); ay <= CoordW'(a1); bx <= CoordW'(b0); by_c <= CoordW'(b1);
    cx <= CoordW'(c0); cy <= CoordW'(c1); dx <= CoordW'(d0); dy <= CoordW'(d1);
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  function automatic int wide_coord();
    return int'($urandom());
  endfunction

  function automatic int near_coord();
    return int'($urandom_range(0, 4000)) - 2000;
  endfunction

  task automatic send_random();
    int k, a0, a1, b0, b1, c0, c1, d0, d1, ux, uy, s;
    k = $urandom_range(0, 9);
    a0 = near_coord(); a1 = near_coord(); b0 = near_coord(); b1 = near_coord();
    c0 = near_coord(); c1 = near_coord(); d0 = near_coord(); d1 = near_coord();
    ux = b0 - a0; uy = b1 - a1;
    case (k)
      0, 1, 2: begin
        a0 = wide_coord(); a1 = wide_coord(); b0 = wide_coord(); b1 = wide_coord();
        c0 = wide_coord(); c1 = wide_coord(); d0 = wide_coord(); d1 = wide_coord();
      end
      3: begin
        s = int'($urandom_range(0, 6)) - 3;
        d0 = c0 + s * ux; d1 = c1 + s * uy;
      end
      4: begin
        b0 = a0; b1 = a1;
      end
      5: begin
        a0 = a0 * 1000; a1 = a1 * 1000; b0 = a0 + ux; b1 = a1 + uy;
        d0 = c0 + ux + 1; d1 = c1 + uy;
      end
      6: begin
        a0 = a0 * 4000; a1 = a1 * 4000; b0 = b0 * 4000; b1 = b1 * 4000;
        c0 = c0 * 4000; c1 = c1 * 4000; d0 = d0 * 4000; d1 = d1 * 4000;
      end
      default: ;
    endcase
    send_pair(a0, a1, b0, b1, c0, c1, d0, d1);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IdleLimit) begin
        $display("tb_line_pair_intersection_core failed");
        $finish;
      end
    end
  end

  initial begin
    int gap;
    idle_cnt = 0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
    end
  end

  initial begin
    int mx, mn;
    mx = 8388607;
    mn = -8388608;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_pair(0, 0, 0, 0, 0, 0, 0, 0);
    send_pair(0, 0, 256, 256, 0, 256, 256, 0);
    send_pair(mx, mx, mn, mn, mx, mn, mn, mx);
    send_pair(mn, mn, mx, mx, mn, mx, mx, mn);
    send_pair(mn, mn, mn, mn, mx, mx, mx, mx);
    send_pair(mx, mn, mx, mn, mn, mx, mn, mx);
    send_pair(0, 0, 256, 0, 0, 512, 256, 512);
    send_pair(-256, 7, 768, 7, -1000, 300, 2000, 300);
    send_pair(mx, 0, mn, 1, 0, mx, 1, mn);
    send_pair(mn, 0, mx, 0, 0, mn, 0, mx);
    send_pair(mx, mx, mx - 1, mx, mn, mn, mn + 1, mn + 1);
    send_pair(mn, mx, mn + 1, mx, mx, mn, mx - 1, mn + 1);
    send_pair(mx, 0, mx, 0, 5, 5, 9, 9);
    send_pair(-1, -1, 1, 1, -1, 1, 1, -1);
    send_pair(100, 200, 300, 400, 500, 700, 700, 900);
    send_pair(mx, mx, 0, 0, mn, 0, 0, mx);
    send_pair(-1, 0, 0, -1, 1, 0, 0, 1);
    send_pair(mn, mn, mx, mx, 1, 0, 0, 1);
    repeat (NumRand) send_random();
    push <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("tb_line_pair_intersection_core passed");
    end else begin
      $display("tb_line_pair_intersection_core failed");
    end
    $finish;
  end

endmodule
